### rtl/core/ethernet_frame_builder_fcs_assert.svh
// Assertion macros shared by the frame builder checkers
`ifndef ETHERNET_FRAME_BUILDER_FCS_ASSERT_SVH
`define ETHERNET_FRAME_BUILDER_FCS_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted
`define EFBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Next-cycle implication, ignored while reset is asserted
`define EFBF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

// Next-cycle implication that also holds through reset
`define EFBF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

### rtl/core/efbf_pkg.sv
// Shared types, constants and CRC table for the Ethernet frame builder
`default_nettype none

package efbf_pkg;

    localparam int unsigned HDR_BYTES = 14;
    localparam int unsigned FCS_BYTES = 4;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEST_MAC   = 2'd0;
    localparam logic [1:0] CFG_SOURCE_MAC = 2'd1;
    localparam logic [1:0] CFG_ETHER_TYPE = 2'd2;

    // One accepted payload word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } t_in_word;

    // One output frame word
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_check;
        logic       frame_end;
    } t_out_word;

    typedef logic [31:0] t_fcs_lut [256];

    // Reflected CRC-32 table, each entry held byte swapped
    function automatic t_fcs_lut f_fcs_lut();
        t_fcs_lut    tab;
        logic [31:0] acc;
        for (int i = 0; i < 256; i++) begin
            acc = 32'(i);
            for (int b = 0; b < 8; b++) begin
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
            end
            tab[i] = {acc[7:0], acc[15:8], acc[23:16], acc[31:24]};
        end
        return tab;
    endfunction

    localparam t_fcs_lut FCS_LUT = f_fcs_lut();

    // One byte step of the running check
    function automatic logic [31:0] f_crc_step(input logic [31:0] crc,
                                               input logic [7:0]  data);
        return {crc[23:0], 8'h00} ^ FCS_LUT[crc[31:24] ^ data];
    endfunction

endpackage

`default_nettype wire

### rtl/core/efbf_in_stage.sv
// Input holding register for one payload word
`default_nettype none

module efbf_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  efbf_pkg::t_in_word  i_word,
    input  wire                 i_pop,
    output logic                o_valid,
    output efbf_pkg::t_in_word  o_word
);
    import efbf_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     w_load;

    // Take a new word when empty or when the held one leaves this cycle
    assign o_ready = !r_valid || i_pop;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

### rtl/core/efbf_seq.sv
// Frame sequencer: header, payload and check byte selection with running CRC
`default_nettype none

module efbf_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_hold_valid,
    input  efbf_pkg::t_in_word  i_hold_word,
    input  wire  [47:0]         i_dest_mac,
    input  wire  [47:0]         i_source_mac,
    input  wire  [15:0]         i_ether_type,
    input  wire                 i_out_free,
    output logic                o_emit,
    output logic                o_pop,
    output efbf_pkg::t_out_word o_word
);
    import efbf_pkg::*;

    typedef enum logic [1:0] {
        ST_HDR,
        ST_DATA,
        ST_FCS
    } t_state;

    localparam logic [3:0] HDR_LAST = 4'(HDR_BYTES - 1);
    localparam logic [1:0] FCS_LAST = 2'(FCS_BYTES - 1);

    t_state      r_state;
    logic [3:0]  r_cnt;
    logic [31:0] r_crc;

    logic [111:0] w_hdr_sh;
    logic [31:0]  w_fcs_sh;
    logic [7:0]   w_data;
    logic [31:0]  n_crc;

    // Header and check bytes go out most significant byte first
    assign w_hdr_sh = {i_dest_mac, i_source_mac, i_ether_type} << {r_cnt, 3'b000};
    assign w_fcs_sh = (~r_crc) << {r_cnt[1:0], 3'b000};

    // Check bytes need no input word; header and payload wait for one
    assign o_emit = (r_state == ST_FCS) ? i_out_free : (i_hold_valid && i_out_free);
    assign o_pop  = o_emit && (r_state == ST_DATA);

    always_comb begin
        unique case (r_state)
            ST_HDR: begin
                w_data = w_hdr_sh[111:104];
            end
            ST_DATA: begin
                w_data = i_hold_word.payload_byte;
            end
            ST_FCS: begin
                w_data = w_fcs_sh[31:24];
            end
            default: begin
                w_data = 8'h00;
            end
        endcase
    end

    assign n_crc = f_crc_step(r_crc, w_data);

    assign o_word.frame_byte = w_data;
    assign o_word.is_check   = (r_state == ST_FCS);
    assign o_word.frame_end  = (r_state == ST_FCS) && (r_cnt[1:0] == FCS_LAST);

    // State, byte counter and running check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HDR;
            r_cnt   <= '0;
            r_crc   <= CRC_INIT;
        end else if (o_emit) begin
            unique case (r_state)
                ST_HDR: begin
                    r_crc <= n_crc;
                    if (r_cnt == HDR_LAST) begin
                        r_state <= ST_DATA;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_DATA: begin
                    r_crc <= n_crc;
                    if (i_hold_word.last_byte) begin
                        r_state <= ST_FCS;
                        r_cnt   <= '0;
                    end
                end
                ST_FCS: begin
                    if (r_cnt[1:0] == FCS_LAST) begin
                        r_state <= ST_HDR;
                        r_cnt   <= '0;
                        r_crc   <= CRC_INIT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                default: begin
                    r_state <= ST_HDR;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/efbf_out_stage.sv
// Output register for one frame word
`default_nettype none

module efbf_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_emit,
    input  efbf_pkg::t_out_word i_word,
    output logic                o_free,
    output logic                o_valid,
    input  wire                 i_ready,
    output efbf_pkg::t_out_word o_word
);
    import efbf_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    // Free when empty or when the receiver takes the current word
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

### rtl/core/ethernet_frame_builder_fcs.sv
// Ethernet frame builder: header insertion and FCS append
//
// Input channel (i_in_valid / o_in_ready) takes one payload byte per word with a
// last-byte mark. Output channel (o_out_valid / i_out_ready) gives one frame byte
// per word, flagged as check byte and, on the fourth check byte, as frame end.
// The first payload word of a frame is preceded by the 14-byte header built
// from the configuration registers (destination MAC, source MAC, ether type).
// After the last payload byte the inverted CRC-32 follows, low byte first.
// Path: a payload word passes the holding register, the sequencer and the output
// register; a frame's first payload byte waits behind the 14 header bytes.
// Throughput: one output byte per cycle while the receiver is ready; mid-frame
// payload is taken one word per cycle while the output is free. Header and
// check bytes do not pop the holding register; input stalls once it is full.
// Configuration writes take effect at once and must be made only while no word
// is in flight, not enforced by the block; a write after the header applies
// from the next header on. Reset clears both registers, the CRC to all ones and
// the registers to zero. When the receiver stalls the output word holds, the
// sequencer stops, and input ready drops once the holding register is full.
`default_nettype none

module ethernet_frame_builder_fcs (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [47:0] i_cfg_data,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_payload_byte,
    input  wire         i_last_byte,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_is_check,
    output logic        o_frame_end
);
    import efbf_pkg::*;

    logic [47:0] r_dest_mac;
    logic [47:0] r_source_mac;
    logic [15:0] r_ether_type;

    t_in_word  w_in_word;
    t_in_word  w_hold_word;
    t_out_word w_seq_word;
    t_out_word w_out_word;
    logic      w_hold_valid;
    logic      w_pop;
    logic      w_emit;
    logic      w_out_free;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_mac   <= '0;
            r_source_mac <= '0;
            r_ether_type <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEST_MAC:   r_dest_mac   <= i_cfg_data;
                CFG_SOURCE_MAC: r_source_mac <= i_cfg_data;
                CFG_ETHER_TYPE: r_ether_type <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign w_in_word.payload_byte = i_payload_byte;
    assign w_in_word.last_byte    = i_last_byte;

    efbf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (w_in_word),
        .i_pop   (w_pop),
        .o_valid (w_hold_valid),
        .o_word  (w_hold_word)
    );

    efbf_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold_valid (w_hold_valid),
        .i_hold_word  (w_hold_word),
        .i_dest_mac   (r_dest_mac),
        .i_source_mac (r_source_mac),
        .i_ether_type (r_ether_type),
        .i_out_free   (w_out_free),
        .o_emit       (w_emit),
        .o_pop        (w_pop),
        .o_word       (w_seq_word)
    );

    efbf_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .i_word  (w_seq_word),
        .o_free  (w_out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (w_out_word)
    );

    assign o_frame_byte = w_out_word.frame_byte;
    assign o_is_check   = w_out_word.is_check;
    assign o_frame_end  = w_out_word.frame_end;

endmodule

`default_nettype wire

### rtl/core/efbf_checker.sv
// Port-level checker for the Ethernet frame builder, bound to the top level
`default_nettype none

`include "ethernet_frame_builder_fcs_assert.svh"

module efbf_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_ready,
    input wire [7:0] o_frame_byte,
    input wire       o_is_check,
    input wire       o_frame_end
);

    // Output word held while stalled
    `EFBF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_frame_byte) && $stable(o_is_check))

    // Frame end marks only a check byte
    `EFBF_ASSERT_IMPLY(a_end_is_check, i_clk, i_rst_n, o_out_valid && o_frame_end, o_is_check)

    // Check bytes run back to back up to the frame end
    `EFBF_ASSERT_NEXT(a_fcs_run, i_clk, i_rst_n, o_out_valid && i_out_ready && o_is_check && !o_frame_end, o_out_valid && o_is_check)

    // Nothing is offered right after reset
    `EFBF_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind ethernet_frame_builder_fcs efbf_checker u_efbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_frame_byte (o_frame_byte),
    .o_is_check   (o_is_check),
    .o_frame_end  (o_frame_end)
);

`default_nettype wire

### tb/testbench.sv
// Testbench for the Ethernet frame builder: directed table, then random frames checked byte by byte
`timescale 1ns / 100ps

module testbench;
    import efbf_pkg::*;

    localparam logic [31:0] FCS_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] FCS_SEED      = 32'hFFFF_FFFF;
    localparam logic [1:0]  CFG_NONE      = 2'd3;   // unmapped index, write must be dropped
    localparam int          DIRECTED_ROWS = 21;
    localparam int          RANDOM_ITEMS  = 190;
    localparam int          TAIL_ITEMS    = 35;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          REPORT_LIMIT  = 40;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;

    // One line of the directed table; first_word is a hand-typed header byte
    typedef struct packed {
        t_row_kind   kind;
        logic [1:0]  reg_index;
        logic [47:0] reg_value;
        logic [7:0]  data;
        logic        last;
        logic        pinned;
        t_out_word   first_word;
    } t_step_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [47:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_payload_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_frame_byte;
    logic        o_is_check;
    logic        o_frame_end;

    // Typed first word travels with the input word so it lines up with acceptance
    logic        pin_first = 1'b0;
    t_out_word   pin_word = '0;

    logic        quiet_tail = 1'b0;
    int          ready_hold = 0;
    int          mismatches = 0;

    // Predictor state: header registers and the reflected CRC register
    logic [47:0] mac_dst;
    logic [47:0] mac_src;
    logic [15:0] eth_type;
    logic [31:0] crc_reflected;
    logic        frame_open;
    t_out_word   frame_bytes_due[$];

    t_step_row   directed_rows [DIRECTED_ROWS];

    ethernet_frame_builder_fcs i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_is_check     (o_is_check),
        .o_frame_end    (o_frame_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Table row builders
    function automatic t_step_row f_byte(input logic [7:0] data, input logic last,
                                         input logic pinned, input t_out_word first_word);
        t_step_row r;
        r            = '0;
        r.kind       = ROW_BYTE;
        r.data       = data;
        r.last       = last;
        r.pinned     = pinned;
        r.first_word = first_word;
        return r;
    endfunction

    function automatic t_step_row f_reg(input logic [1:0] idx, input logic [47:0] value);
        t_step_row r;
        r           = '0;
        r.kind      = ROW_REG;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    // Frame byte that enters the check: fold into CRC and queue as a data word
    function automatic void push_data(input logic [7:0] b);
        crc_reflected = crc_reflected ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            crc_reflected = crc_reflected[0] ? ((crc_reflected >> 1) ^ FCS_POLY)
                                             : (crc_reflected >> 1);
        end
        frame_bytes_due.push_back('{frame_byte: b, is_check: 1'b0, frame_end: 1'b0});
    endfunction

    // Expected words for one accepted payload word
    function automatic void build_frame_bytes(input logic [7:0] data, input logic last);
        logic [31:0] fcs;
        if (!frame_open) begin
            crc_reflected = FCS_SEED;
            for (int k = 0; k < 6; k++) push_data(mac_dst[47 - 8 * k -: 8]);
            for (int k = 0; k < 6; k++) push_data(mac_src[47 - 8 * k -: 8]);
            push_data(eth_type[15:8]);
            push_data(eth_type[7:0]);
            frame_open = 1'b1;
        end
        push_data(data);
        if (last) begin
            // reflected register: lowest byte goes out first
            fcs = ~crc_reflected;
            for (int k = 0; k < 4; k++) begin
                frame_bytes_due.push_back('{frame_byte: fcs[8 * k +: 8], is_check: 1'b1,
                                            frame_end: (k == 3)});
            end
            crc_reflected = FCS_SEED;
            frame_open    = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            end
        end
    endfunction

    // Predict on accepted words, compare on delivered words
    always @(posedge i_clk) begin
        int        base;
        t_out_word want;
        if (!i_rst_n) begin
            mac_dst       = '0;
            mac_src       = '0;
            eth_type      = '0;
            crc_reflected = FCS_SEED;
            frame_open    = 1'b0;
            frame_bytes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEST_MAC:   mac_dst  = i_cfg_data;
                    CFG_SOURCE_MAC: mac_src  = i_cfg_data;
                    CFG_ETHER_TYPE: eth_type = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                base = frame_bytes_due.size();
                build_frame_bytes(i_payload_byte, i_last_byte);
                if (pin_first) frame_bytes_due[base] = pin_word;
            end
            if (o_out_valid && i_out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: unexpected word, expected none, actual %h/%b/%b",
                                 $time, o_frame_byte, o_is_check, o_frame_end);
                    end
                end else begin
                    want = frame_bytes_due.pop_front();
                    check_field("frame_byte", want.frame_byte, o_frame_byte);
                    check_field("is_check", 8'(want.is_check), 8'(o_is_check));
                    check_field("frame_end", 8'(want.frame_end), 8'(o_frame_end));
                end
            end
        end
    end

    // Receiver: ready in random stretches, broken by random stalls
    always @(posedge i_clk) begin
        if (quiet_tail) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if (i_out_ready && $urandom_range(0, 2) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold = $urandom_range(0, 16);
        end else begin
            i_out_ready <= 1'b1;
            ready_hold = $urandom_range(0, 30);
        end
    end

    // Present one payload word, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] data, input logic last,
                             input logic pinned, input t_out_word first_word);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_payload_byte <= data;
        i_last_byte    <= last;
        pin_first      <= pinned;
        pin_word       <= first_word;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Register write once all expected words are out and the pipe has settled
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (frame_bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic write_random_reg();
        logic [47:0] value;
        case ($urandom_range(0, 3))
            0:       value = '0;
            1:       value = '1;
            default: value = 48'({$urandom(), $urandom()});
        endcase
        write_reg(2'($urandom_range(0, 3)), value);
    endtask

    // Main sequence
    initial begin
        t_step_row  row;
        int         sent;
        int         len;
        logic [7:0] b;

        directed_rows = '{
            // header from reset values
            f_byte(8'h00, 1'b0, 1'b1, '{frame_byte: 8'h00, is_check: 1'b0, frame_end: 1'b0}),
            f_byte(8'hFF, 1'b1, 1'b0, '0),
            f_reg(CFG_DEST_MAC,   48'hFFFF_FFFF_FFFF),
            f_reg(CFG_SOURCE_MAC, 48'hFFFF_FFFF_FFFF),
            f_reg(CFG_ETHER_TYPE, 48'h0000_0000_FFFF),
            f_reg(CFG_NONE,       48'h0000_0000_0000),
            // single-byte frame: header, byte and check in one go
            f_byte(8'hFF, 1'b1, 1'b1, '{frame_byte: 8'hFF, is_check: 1'b0, frame_end: 1'b0}),
            f_reg(CFG_SOURCE_MAC, 48'h0123_4567_89AB),
            // bits above the ether type width are dropped
            f_reg(CFG_ETHER_TYPE, 48'hFFFF_FFFF_0800),
            f_byte(8'h55, 1'b0, 1'b1, '{frame_byte: 8'hFF, is_check: 1'b0, frame_end: 1'b0}),
            // write inside an open frame, takes effect on the next header
            f_reg(CFG_DEST_MAC,   48'h0000_0000_0000),
            f_byte(8'hAA, 1'b0, 1'b0, '0),
            f_byte(8'h01, 1'b1, 1'b0, '0),
            f_byte(8'h80, 1'b1, 1'b1, '{frame_byte: 8'h00, is_check: 1'b0, frame_end: 1'b0}),
            f_reg(CFG_NONE,       48'hFFFF_FFFF_FFFF),
            f_byte(8'h7F, 1'b0, 1'b0, '0),
            f_byte(8'hFE, 1'b0, 1'b0, '0),
            f_byte(8'h00, 1'b1, 1'b0, '0),
            f_reg(CFG_ETHER_TYPE, 48'h0000_0000_0000),
            f_reg(CFG_SOURCE_MAC, 48'h0000_0000_0000),
            f_byte(8'h5A, 1'b1, 1'b1, '{frame_byte: 8'h00, is_check: 1'b0, frame_end: 1'b0})
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_REG) begin
                write_reg(row.reg_index, row.reg_value);
            end else begin
                send_byte(row.data, row.last, row.pinned, row.first_word);
            end
        end

        // random frames, mostly short, some long, occasional register changes
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) write_random_reg();
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 46) : $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                if (j > 0 && $urandom_range(0, 29) == 0) write_random_reg();
                case ($urandom_range(0, 9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                send_byte(b, j == len - 1, 1'b0, '0);
                sent++;
                if (sent >= RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
            end
        end
        i_in_valid <= 1'b0;

        // drain
        do @(posedge i_clk); while (frame_bytes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_bytes_due.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
